// File: rtl/ssog_pkg.sv
// Shared types, constants and microcode for the stereo sub-octave generator.
package ssog_pkg;

  // Default widths for the sample and filter-state formats
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STATE_WIDTH_DEF  = 24;

  // Configuration port geometry
  localparam int GAIN_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_LP_COEFF = 2'd1,
    CFG_AMOUNT   = 2'd2,
    CFG_MIX      = 2'd3
  } cfg_index_t;

  localparam logic              ENABLE_RESET   = 1'b1;
  localparam logic [GAIN_W-1:0] LP_COEFF_RESET = 16'd683;
  localparam logic [GAIN_W-1:0] AMOUNT_RESET   = 16'd16384;
  localparam logic [GAIN_W-1:0] MIX_RESET      = 16'd16384;

  // 0.3 in Q0.16
  localparam logic [GAIN_W-1:0] DRY_SCALE = 16'd19661;

  // Dry gain in Q1.15: 1.0 - 0.3*mix, rounded
  function automatic logic [GAIN_W-1:0] dry_gain_of(input logic [GAIN_W-1:0] m);
    logic [31:0] p;
    p = 32'(m) * 32'(DRY_SCALE) + 32'd32768;
    return 16'(32'd32768 - 32'(p[31:16]));
  endfunction

  localparam logic [GAIN_W-1:0] DRY_GAIN_RESET = dry_gain_of(MIX_RESET);

  // Microcode geometry
  localparam int STEP_W    = 4;
  localparam int NUM_STEPS = 11;
  localparam logic [STEP_W-1:0] OUT_STEP = 4'd9;

  // Multiplier operand pair selected in a step
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_LP1  = 3'd1,
    MUL_LP2  = 3'd2,
    MUL_SUB  = 3'd3,
    MUL_DRY  = 3'd4,
    MUL_WET  = 3'd5
  } mul_op_t;

  // Register written from the product of the previous step
  typedef enum logic [2:0] {
    WR_NONE = 3'd0,
    WR_FS   = 3'd1,
    WR_SS   = 3'd2,
    WR_SUB  = 3'd3,
    WR_ACC  = 3'd4,
    WR_OUT  = 3'd5
  } wr_op_t;

  typedef struct packed {
    mul_op_t           mop;
    logic              mch;
    wr_op_t            wop;
    logic              wch;
    logic              jmp_byp;
    logic [STEP_W-1:0] target;
    logic              wait_out;
    logic              last;
  } ctrl_t;

  function automatic ctrl_t cw(input mul_op_t mop, input logic mch,
                               input wr_op_t wop, input logic wch);
    ctrl_t c;
    c          = '0;
    c.mop      = mop;
    c.mch      = mch;
    c.wop      = wop;
    c.wch      = wch;
    c.jmp_byp  = 1'b0;
    c.target   = '0;
    c.wait_out = 1'b0;
    c.last     = 1'b0;
    return c;
  endfunction

  // Program: both channels interleaved on one multiplier
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = cw(MUL_NONE, 1'b0, WR_NONE, 1'b0);
    case (step)
      4'd0: begin
        c         = cw(MUL_LP1, 1'b0, WR_NONE, 1'b0);
        c.jmp_byp = 1'b1;
        c.target  = OUT_STEP;
      end
      4'd1: c = cw(MUL_LP1, 1'b1, WR_FS,  1'b0);
      4'd2: c = cw(MUL_LP2, 1'b0, WR_FS,  1'b1);
      4'd3: c = cw(MUL_LP2, 1'b1, WR_SS,  1'b0);
      4'd4: c = cw(MUL_SUB, 1'b0, WR_SS,  1'b1);
      4'd5: c = cw(MUL_SUB, 1'b1, WR_SUB, 1'b0);
      4'd6: c = cw(MUL_DRY, 1'b0, WR_SUB, 1'b1);
      4'd7: c = cw(MUL_DRY, 1'b1, WR_ACC, 1'b0);
      4'd8: c = cw(MUL_WET, 1'b0, WR_ACC, 1'b1);
      4'd9: begin
        c          = cw(MUL_WET, 1'b1, WR_OUT, 1'b0);
        c.wait_out = 1'b1;
      end
      4'd10: begin
        c      = cw(MUL_NONE, 1'b0, WR_OUT, 1'b1);
        c.last = 1'b1;
      end
      default: begin
        c      = cw(MUL_NONE, 1'b0, WR_NONE, 1'b0);
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/stereo_sub_octave_generator_unit.sv
// Top level of the stereo sub-octave generator: config registers and handshakes.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   left_in, right_in
// out      output     out_valid / out_ready left_out, right_out
// cfg      input      cfg_we (no wait)      cfg_index, cfg_data
//
// Enabled: a frame runs all 11 steps of the microcode and then returns to idle; one shared
// multiplier computes five products per channel.
// Disabled: the program jumps from the first step straight to the output steps.
// Reset loads the register defaults and clears the filter state and phases at once.
// The output step holds while the previous result waits; the input stays closed until
// the frame finishes.
module stereo_sub_octave_generator_unit #(
  parameter int SAMPLE_WIDTH = ssog_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = ssog_pkg::STATE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]        left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]        right_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        left_out,
  output logic signed [SAMPLE_WIDTH-1:0]        right_out,
  input  logic                                  cfg_we,
  input  logic [ssog_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ssog_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic                          enable;
  logic [ssog_pkg::GAIN_W-1:0]   lp_coeff;
  logic [ssog_pkg::GAIN_W-1:0]   amount;
  logic [ssog_pkg::GAIN_W-1:0]   mix;
  logic [ssog_pkg::GAIN_W-1:0]   dry_gain;
  logic                          bypass;
  logic signed [SAMPLE_WIDTH-1:0] x0;
  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic                          start;
  logic                          idle;
  logic                          fire;
  logic                          out_busy;
  ssog_pkg::ctrl_t               ctrl;

  assign in_ready = idle;
  assign start    = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  // Configuration writes; dry gain follows mix
  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= ssog_pkg::ENABLE_RESET;
      lp_coeff <= ssog_pkg::LP_COEFF_RESET;
      amount   <= ssog_pkg::AMOUNT_RESET;
      mix      <= ssog_pkg::MIX_RESET;
      dry_gain <= ssog_pkg::DRY_GAIN_RESET;
    end else if (cfg_we) begin
      case (ssog_pkg::cfg_index_t'(cfg_index))
        ssog_pkg::CFG_ENABLE:   enable   <= cfg_data[0];
        ssog_pkg::CFG_LP_COEFF: lp_coeff <= cfg_data;
        ssog_pkg::CFG_AMOUNT:   amount   <= cfg_data;
        ssog_pkg::CFG_MIX: begin
          mix      <= cfg_data;
          dry_gain <= ssog_pkg::dry_gain_of(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // Capture the frame on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else if (start) begin
      bypass <= !enable;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x0 <= left_in;
      x1 <= right_in;
    end
  end

  // Raise valid after the last step, drop it on the output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ctrl.last) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  ssog_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .bypass   (bypass),
    .out_busy (out_busy),
    .ctrl     (ctrl),
    .fire     (fire),
    .idle     (idle)
  );

  ssog_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .fire     (fire),
    .bypass   (bypass),
    .lp_coeff (lp_coeff),
    .amount   (amount),
    .mix      (mix),
    .dry_gain (dry_gain),
    .x0       (x0),
    .x1       (x1),
    .y0       (left_out),
    .y1       (right_out)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again before the frame finished");

  a_valid_from_last_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire && ctrl.last))
    else $error("output valid raised outside the last step");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl.wop == ssog_pkg::WR_OUT |-> !out_valid || out_ready)
    else $error("pending result overwritten");

endmodule

// File: rtl/ssog_seq.sv
// Microcode sequencer: step counter, control ROM and bypass jump.
module ssog_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            bypass,
  input  logic            out_busy,
  output ssog_pkg::ctrl_t ctrl,
  output logic            fire,
  output logic            idle
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                      state;
  seq_state_t                      state_next;
  logic [ssog_pkg::STEP_W-1:0]     step;
  logic [ssog_pkg::STEP_W-1:0]     step_next;

  // Fetch the control word of the current step
  assign ctrl = ssog_pkg::ucode(step);
  assign idle = (state == ST_IDLE);

  // Hold the output step while the previous result is still pending
  assign fire = (state == ST_RUN) && !(ctrl.wait_out && out_busy);

  // Advance, jump or finish
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (fire) begin
          if (ctrl.last) begin
            state_next = ST_IDLE;
          end else if (ctrl.jmp_byp && bypass) begin
            step_next = ctrl.target;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  a_step_in_program: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> 32'(step) < ssog_pkg::NUM_STEPS)
    else $error("sequencer step outside the program");

endmodule

// File: rtl/ssog_dp.sv
// Datapath: shared multiplier, filter state, sub-octave phase and output mix.
module ssog_dp #(
  parameter int SAMPLE_WIDTH = ssog_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = ssog_pkg::STATE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ssog_pkg::ctrl_t                     ctrl,
  input  logic                                fire,
  input  logic                                bypass,
  input  logic [ssog_pkg::GAIN_W-1:0]         lp_coeff,
  input  logic [ssog_pkg::GAIN_W-1:0]         amount,
  input  logic [ssog_pkg::GAIN_W-1:0]         mix,
  input  logic [ssog_pkg::GAIN_W-1:0]         dry_gain,
  input  logic signed [SAMPLE_WIDTH-1:0]      x0,
  input  logic signed [SAMPLE_WIDTH-1:0]      x1,
  output logic signed [SAMPLE_WIDTH-1:0]      y0,
  output logic signed [SAMPLE_WIDTH-1:0]      y1
);

  localparam int XW   = SAMPLE_WIDTH;
  localparam int SW   = STATE_WIDTH;
  localparam int D    = SW - XW;
  localparam int ND   = (D < 0) ? -D : 0;
  localparam int AW   = SW + 2;
  localparam int BW   = ssog_pkg::GAIN_W + 1;
  localparam int PW   = AW + BW;
  localparam int UW   = SW + 3;
  localparam int SUMW = SW + 4;
  localparam int YW   = SUMW + ND;

  logic signed [XW-1:0]   xin [2];
  logic signed [SW-1:0]   xs [2];
  logic signed [SW-1:0]   fs [2];
  logic signed [SW-1:0]   ss [2];
  logic                   lneg [2];
  logic                   phase [2];
  logic signed [AW-1:0]   sub [2];
  logic signed [SW:0]     acc [2];
  logic signed [XW-1:0]   y [2];
  logic signed [PW-1:0]   prod;

  logic signed [AW-1:0]   a;
  logic signed [BW-1:0]   b;
  logic signed [PW-1:0]   mul;
  logic signed [AW-1:0]   bass;
  logic signed [AW-1:0]   mag;
  logic signed [AW-1:0]   smag;
  logic signed [SW-1:0]   cur;
  logic signed [UW-1:0]   upd_sum;
  logic signed [SW-1:0]   upd_sat;
  logic signed [UW-1:0]   wet;
  logic signed [SUMW-1:0] sum;
  logic signed [YW-1:0]   yr;
  logic signed [XW-1:0]   ysat;

  assign xin[0] = x0;
  assign xin[1] = x1;
  assign y0     = y[0];
  assign y1     = y[1];

  // Bring samples into the state format
  for (genvar c = 0; c < 2; c++) begin : g_xs
    if (D >= 0) begin : g_up
      assign xs[c] = SW'(xin[c]) <<< D;
    end else begin : g_dn
      assign xs[c] = SW'(xin[c] >>> ND);
    end
  end

  // Signed sub magnitude: +|bass| when phase set, -|bass| otherwise
  assign bass = AW'(ss[ctrl.mch]);
  assign mag  = bass[AW-1] ? -bass : bass;
  assign smag = phase[ctrl.mch] ? mag : -mag;

  // Select multiplier operands
  always_comb begin
    a = '0;
    b = '0;
    case (ctrl.mop)
      ssog_pkg::MUL_LP1: begin
        a = AW'(xs[ctrl.mch]) - AW'(fs[ctrl.mch]);
        b = $signed({1'b0, lp_coeff});
      end
      ssog_pkg::MUL_LP2: begin
        a = AW'(fs[ctrl.mch]) - AW'(ss[ctrl.mch]);
        b = $signed({1'b0, lp_coeff});
      end
      ssog_pkg::MUL_SUB: begin
        a = smag;
        b = $signed({1'b0, amount});
      end
      ssog_pkg::MUL_DRY: begin
        a = AW'(xs[ctrl.mch]);
        b = $signed({1'b0, dry_gain});
      end
      ssog_pkg::MUL_WET: begin
        a = sub[ctrl.mch];
        b = $signed({1'b0, mix});
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign mul = a * b;

  always_ff @(posedge clk) begin
    if (fire && ctrl.mop != ssog_pkg::MUL_NONE) begin
      prod <= mul;
    end
  end

  // Filter stage update: state + floor(prod / 2^16), saturated
  assign cur     = (ctrl.wop == ssog_pkg::WR_SS) ? ss[ctrl.wch] : fs[ctrl.wch];
  assign upd_sum = UW'(cur) + $signed(prod[PW-1:16]);
  always_comb begin
    if (&upd_sum[UW-1:SW-1] || ~|upd_sum[UW-1:SW-1]) begin
      upd_sat = SW'(upd_sum);
    end else if (upd_sum[UW-1]) begin
      upd_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      upd_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Output: dry + wet, round half up into the sample format (when the state is wider), saturate
  assign wet = $signed(prod[SW+17:15]);
  assign sum = SUMW'(acc[ctrl.wch]) + SUMW'(wet);

  if (D > 0) begin : g_round
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (D - 1);
    assign yr = (sum + HALF) >>> D;
  end else if (D == 0) begin : g_same
    assign yr = sum;
  end else begin : g_widen
    assign yr = YW'(sum) <<< ND;
  end

  always_comb begin
    if (&yr[YW-1:XW-1] || ~|yr[YW-1:XW-1]) begin
      ysat = XW'(yr);
    end else if (yr[YW-1]) begin
      ysat = {1'b1, {(XW-1){1'b0}}};
    end else begin
      ysat = {1'b0, {(XW-1){1'b1}}};
    end
  end

  // Filter state and sub-octave phase
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        fs[c]    <= '0;
        ss[c]    <= '0;
        lneg[c]  <= 1'b0;
        phase[c] <= 1'b0;
      end
    end else if (fire) begin
      case (ctrl.wop)
        ssog_pkg::WR_FS: begin
          fs[ctrl.wch] <= upd_sat;
        end
        ssog_pkg::WR_SS: begin
          ss[ctrl.wch]   <= upd_sat;
          lneg[ctrl.wch] <= upd_sat[SW-1];
          // toggle on every sign change of the bass
          if (upd_sat[SW-1] != lneg[ctrl.wch]) begin
            phase[ctrl.wch] <= !phase[ctrl.wch];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Intermediate products and results
  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctrl.wop)
        ssog_pkg::WR_SUB: sub[ctrl.wch] <= $signed(prod[AW+14:15]);
        ssog_pkg::WR_ACC: acc[ctrl.wch] <= $signed(prod[SW+15:15]);
        ssog_pkg::WR_OUT: y[ctrl.wch]   <= bypass ? xin[ctrl.wch] : ysat;
        default: begin
        end
      endcase
    end
  end

endmodule
